/* sv/utc_date_to_epoch_seconds_top_defines.svh */
// assertion macros for the date to epoch seconds block
// expects clk and rst_n in the scope where a macro is used
`ifndef UTC_DATE_TO_EPOCH_SECONDS_TOP_DEFINES_SVH
`define UTC_DATE_TO_EPOCH_SECONDS_TOP_DEFINES_SVH

// same-cycle implication
`define UTCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/utce_pkg.sv */
// shared types, constants and the month table for the date to epoch seconds block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package utce_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int SECS_W   = 37;
    localparam int DAYS_W   = 20;
    localparam int HMS_W    = 17;
    localparam int Q100_W   = 6;
    localparam int MSTART_W = 9;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 1;

    localparam int NUM_STAGES = 4;

    localparam int YEAR_LO   = 0;
    localparam int MONTH_LO  = YEAR_LO + YEAR_W;
    localparam int DAY_LO    = MONTH_LO + MONTH_W;
    localparam int HOUR_LO   = DAY_LO + DAY_W;
    localparam int MINUTE_LO = HOUR_LO + HOUR_W;
    localparam int SECOND_LO = MINUTE_LO + MINUTE_W;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;

    // floor(n / 100) = (n * 5243) >> 19 for n below 4096
    localparam int DIV100_MUL_W = 13;
    localparam int DIV100_PROD_W = YEAR_W + DIV100_MUL_W;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SHIFT = 19;
    localparam logic [DIV100_MUL_W-1:0] CENTURY = 13'd100;

    // leap years in 1..1969
    localparam logic [DAYS_W-1:0] LEAPS_BEFORE_EPOCH = 20'd477;
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR      = 20'd365;

    localparam logic [SECS_W-1:0] SECS_PER_DAY  = 37'd86400;
    localparam logic [HMS_W-1:0]  SECS_PER_HOUR = 17'd3600;
    localparam logic [HMS_W-1:0]  SECS_PER_MIN  = 17'd60;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctl_t;

    // days before the first of the month in a common year
    function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSTART_W-1:0] d;
        case (m)
            MONTH_JAN: d = 9'd0;
            MONTH_FEB: d = 9'd31;
            MONTH_MAR: d = 9'd59;
            MONTH_APR: d = 9'd90;
            MONTH_MAY: d = 9'd120;
            MONTH_JUN: d = 9'd151;
            MONTH_JUL: d = 9'd181;
            MONTH_AUG: d = 9'd212;
            MONTH_SEP: d = 9'd243;
            MONTH_OCT: d = 9'd273;
            MONTH_NOV: d = 9'd304;
            MONTH_DEC: d = 9'd334;
            default:   d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* sv/utce_pipe_ctl.sv */
// valid bits and per-stage load enables for the conversion pipeline
// depends on utce_pkg
`timescale 1ns / 1ps
`default_nettype none

module utce_pipe_ctl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_ready,
    output utce_pkg::pipe_ctl_t     ctl
);
    import utce_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    // a stage loads when empty or when the stage after it moves
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load  = load;
    assign ctl.valid = valid_reg;

endmodule

`default_nettype wire

/* sv/utc_date_to_epoch_seconds_top.sv */
// Converts a UTC calendar date and time to seconds since 1970-01-01 00:00:00.
// Four register stages: input split with the divide-by-100 reciprocal
// multiplies, leap and day count, days times 86400, final add and mask.
// One word per clock is accepted while the output is not stalled; each result
// passes through the stage registers in order to the output, and the pipeline holds
// without loss while the output is stalled.
// Years below 1970, month 0 or above 12, or day 0 flag invalid with zero
// seconds; day, hour, minute and second are added without upper bound checks.
// depends on utce_pkg, utce_pipe_ctl and utc_date_to_epoch_seconds_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "utc_date_to_epoch_seconds_top_defines.svh"

module utc_date_to_epoch_seconds_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
    // second[37:32], zero pad
    input  wire logic [utce_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // seconds[36:0], zero pad
    output logic [utce_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // invalid[0]
    output logic [utce_pkg::M_USER_W-1:0]      m_axis_tuser
);
    import utce_pkg::*;

    pipe_ctl_t ctl;

    utce_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctl       (ctl)
    );

    // stage 1: split fields, range check, divide by 100
    logic [YEAR_W-1:0]        year_in;
    logic [MONTH_W-1:0]       month_in;
    logic [DAY_W-1:0]         day_in;
    logic [YEAR_W-1:0]        yearm1_in;
    logic [DIV100_PROD_W-1:0] prod_n;
    logic [DIV100_PROD_W-1:0] prod_y;
    logic                     inv_in;

    assign year_in   = s_axis_tdata[YEAR_LO +: YEAR_W];
    assign month_in  = s_axis_tdata[MONTH_LO +: MONTH_W];
    assign day_in    = s_axis_tdata[DAY_LO +: DAY_W];
    assign yearm1_in = year_in - 12'd1;
    assign prod_n    = {{DIV100_MUL_W{1'b0}}, yearm1_in} * {{YEAR_W{1'b0}}, DIV100_MUL};
    assign prod_y    = {{DIV100_MUL_W{1'b0}}, year_in} * {{YEAR_W{1'b0}}, DIV100_MUL};
    assign inv_in    = (year_in < EPOCH_YEAR) || (month_in < MONTH_JAN)
                    || (month_in > MONTH_DEC) || (day_in == '0);

    logic                inv1_reg;
    logic [YEAR_W-1:0]   year1_reg;
    logic [MONTH_W-1:0]  month1_reg;
    logic [DAY_W-1:0]    day1_reg;
    logic [HOUR_W-1:0]   hour1_reg;
    logic [MINUTE_W-1:0] minute1_reg;
    logic [SECOND_W-1:0] second1_reg;
    logic [Q100_W-1:0]   q100n1_reg;
    logic [Q100_W-1:0]   q100y1_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            inv1_reg    <= inv_in;
            year1_reg   <= year_in;
            month1_reg  <= month_in;
            day1_reg    <= day_in;
            hour1_reg   <= s_axis_tdata[HOUR_LO +: HOUR_W];
            minute1_reg <= s_axis_tdata[MINUTE_LO +: MINUTE_W];
            second1_reg <= s_axis_tdata[SECOND_LO +: SECOND_W];
            q100n1_reg  <= prod_n[DIV100_SHIFT +: Q100_W];
            q100y1_reg  <= prod_y[DIV100_SHIFT +: Q100_W];
        end
    end

    // stage 2: leap year, leap count, day count, time of day
    logic [DIV100_MUL_W-1:0] hundreds;
    logic                    cent;
    logic                    leap;
    logic [YEAR_W-1:0]       yearm1_1;
    logic [YEAR_W-1:0]       yoff;
    logic [DAYS_W-1:0]       days_next;
    logic [HMS_W-1:0]        hms_next;

    assign hundreds = {{(DIV100_MUL_W-Q100_W){1'b0}}, q100y1_reg} * CENTURY;
    assign cent     = ({{(DIV100_MUL_W-YEAR_W){1'b0}}, year1_reg} == hundreds);
    assign leap     = ((year1_reg[1:0] == 2'b00) && !cent)
                   || (cent && (q100y1_reg[1:0] == 2'b00));
    assign yearm1_1 = year1_reg - 12'd1;
    assign yoff     = year1_reg - EPOCH_YEAR;

    always_comb
    begin
        days_next = {{(DAYS_W-YEAR_W){1'b0}}, yoff} * DAYS_PER_YEAR
                  + {{(DAYS_W-YEAR_W+2){1'b0}}, yearm1_1[YEAR_W-1:2]}
                  - {{(DAYS_W-Q100_W){1'b0}}, q100n1_reg}
                  + {{(DAYS_W-Q100_W+2){1'b0}}, q100n1_reg[Q100_W-1:2]}
                  - LEAPS_BEFORE_EPOCH
                  + {{(DAYS_W-MSTART_W){1'b0}}, month_start(month1_reg)}
                  + {{(DAYS_W-1){1'b0}}, (leap && (month1_reg > MONTH_FEB))}
                  + {{(DAYS_W-DAY_W){1'b0}}, day1_reg}
                  - 20'd1;
        hms_next  = {{(HMS_W-HOUR_W){1'b0}}, hour1_reg} * SECS_PER_HOUR
                  + {{(HMS_W-MINUTE_W){1'b0}}, minute1_reg} * SECS_PER_MIN
                  + {{(HMS_W-SECOND_W){1'b0}}, second1_reg};
    end

    logic              inv2_reg;
    logic [DAYS_W-1:0] days2_reg;
    logic [HMS_W-1:0]  hms2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            inv2_reg  <= inv1_reg;
            days2_reg <= days_next;
            hms2_reg  <= hms_next;
        end
    end

    // stage 3: days to seconds
    logic              inv3_reg;
    logic [SECS_W-1:0] dsec3_reg;
    logic [HMS_W-1:0]  hms3_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            inv3_reg  <= inv2_reg;
            dsec3_reg <= {{(SECS_W-DAYS_W){1'b0}}, days2_reg} * SECS_PER_DAY;
            hms3_reg  <= hms2_reg;
        end
    end

    // stage 4: final sum, zeroed for invalid words, into the output register
    logic              inv4_reg;
    logic [SECS_W-1:0] secs4_reg;
    logic [SECS_W-1:0] secs_next;

    assign secs_next = inv3_reg ? '0 : dsec3_reg + {{(SECS_W-HMS_W){1'b0}}, hms3_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            inv4_reg  <= inv3_reg;
            secs4_reg <= secs_next;
        end
    end

    assign s_axis_tready = ctl.load[0];
    assign m_axis_tvalid = ctl.valid[NUM_STAGES-1];
    assign m_axis_tdata  = {{(M_DATA_W-SECS_W){1'b0}}, secs4_reg};
    assign m_axis_tuser  = inv4_reg;

    `UTCE_ASSERT_IMP(a_invalid_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0,
        "invalid word carries nonzero seconds")
    `UTCE_ASSERT_IMP(a_ready_when_empty, !ctl.valid[0], s_axis_tready,
        "input not ready with first stage empty")
    `UTCE_ASSERT_NXT(a_accept_fills, s_axis_tvalid && s_axis_tready, ctl.valid[0],
        "accepted word not in first stage")
    `UTCE_ASSERT_NXT(a_early_year, s_axis_tvalid && s_axis_tready
        && (s_axis_tdata[YEAR_LO +: YEAR_W] < EPOCH_YEAR), inv1_reg,
        "year before epoch not flagged")

endmodule

`default_nettype wire
